/* rtl/core/npe_pkg.sv */
// shared types, constants and fixed-point helpers of the normalized polynomial evaluator
`default_nettype none

package npe_pkg;

    localparam int DATA_W    = 32;
    localparam int MAX_ORDER = 5;
    localparam int NUM_POW   = MAX_ORDER + 1;
    localparam int NUM_COEFF = 6;
    localparam int MASK_W    = 6;
    localparam int USE_W     = (NUM_POW < MASK_W) ? NUM_POW : MASK_W;
    localparam int IDX_W     = (NUM_POW > 1) ? $clog2(NUM_POW) : 1;
    localparam int PIDX_W    = 3;
    localparam int CFG_IDX_W = 3;

    localparam int NSTG     = 2 * MAX_ORDER + 3;
    localparam int ST_TERM  = MAX_ORDER + 1;
    localparam int ST_ACC0  = MAX_ORDER + 2;
    localparam int LAST_ST  = NSTG - 1;

    localparam int Q_DEPTH  = 4;
    localparam int Q_PTR_W  = 2;
    localparam int Q_CNT_W  = 3;

    localparam logic KIND_EVAL  = 1'b0;
    localparam logic KIND_BASIS = 1'b1;

    localparam logic [CFG_IDX_W-1:0] REG_COEFF_FIRST = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_COEFF_LAST  = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_OFFSET      = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_INV_SCALE   = 3'd7;

    typedef logic signed [DATA_W-1:0] q16_t;

    localparam q16_t ONE_Q16  = 32'sh0001_0000;
    localparam q16_t ZERO_Q16 = 32'sh0000_0000;
    localparam q16_t Q16_MAX  = 32'sh7fff_ffff;
    localparam q16_t Q16_MIN  = 32'sh8000_0000;

    typedef struct packed {
        logic                   kind;
        logic [USE_W-1:0]       mask;
        q16_t                   u;
        q16_t [NUM_POW-1:0]     pw;
        q16_t [NUM_POW-1:0]     term;
        q16_t                   acc;
    } stage_t;

    typedef struct packed {
        logic                   kind;
        logic [USE_W-1:0]       mask;
        q16_t                   acc;
        q16_t [NUM_POW-1:0]     pw;
    } entry_t;

    function automatic q16_t sat_sub(input q16_t a, input q16_t b);
        logic [DATA_W:0] t;
        t = {a[DATA_W-1], a} - {b[DATA_W-1], b};
        if (t[DATA_W] != t[DATA_W-1])
            return t[DATA_W] ? Q16_MIN : Q16_MAX;
        return q16_t'(t[DATA_W-1:0]);
    endfunction

    function automatic q16_t sat_add(input q16_t a, input q16_t b);
        logic [DATA_W:0] t;
        t = {a[DATA_W-1], a} + {b[DATA_W-1], b};
        if (t[DATA_W] != t[DATA_W-1])
            return t[DATA_W] ? Q16_MIN : Q16_MAX;
        return q16_t'(t[DATA_W-1:0]);
    endfunction

    // q16.16 product, round half up, saturated
    function automatic q16_t mul_q16(input q16_t a, input q16_t b);
        logic signed [2*DATA_W-1:0] p;
        logic [DATA_W+15:0]         sh;
        p  = 64'(a) * 64'(b);
        p  = p + 64'sd32768;
        sh = p[2*DATA_W-1:16];
        if (sh[DATA_W+15:DATA_W-1] == '0 || sh[DATA_W+15:DATA_W-1] == '1)
            return q16_t'(sh[DATA_W-1:0]);
        return sh[DATA_W+15] ? Q16_MIN : Q16_MAX;
    endfunction

endpackage

`default_nettype wire

/* rtl/core/npe_in_if.sv */
// sample channel interface
`default_nettype none

interface npe_in_if;
    import npe_pkg::*;

    logic              valid;
    logic              ready;
    logic              kind;
    q16_t              x;
    logic [MASK_W-1:0] power_mask;

    modport source (output valid, kind, x, power_mask, input ready);
    modport sink   (input valid, kind, x, power_mask, output ready);
endinterface

`default_nettype wire

/* rtl/core/npe_out_if.sv */
// result channel interface
`default_nettype none

interface npe_out_if;
    import npe_pkg::*;

    logic              valid;
    logic              ready;
    q16_t              result_value;
    logic [PIDX_W-1:0] power_index;
    logic              last;

    modport source (output valid, result_value, power_index, last, input ready);
    modport sink   (input valid, result_value, power_index, last, output ready);
endinterface

`default_nettype wire

/* rtl/core/npe_cfg_if.sv */
// register write channel interface
`default_nettype none

interface npe_cfg_if;
    import npe_pkg::*;

    logic                 valid;
    logic                 ready;
    logic [CFG_IDX_W-1:0] index;
    q16_t                 data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

/* rtl/core/npe_front.sv */
// front end: registers, normalization, power chain, terms and running sum
`default_nettype none

module npe_front (
    input  wire logic     clk,
    input  wire logic     rst_n,
    npe_in_if.sink        sample,
    npe_cfg_if.sink       cfg,
    input  wire logic     q_full,
    output logic          push_valid,
    output npe_pkg::entry_t push_data
);
    import npe_pkg::*;

    q16_t coeff_reg [NUM_COEFF];
    q16_t offset_reg;
    q16_t inv_scale_reg;
    q16_t coef_ext [NUM_POW];

    logic [NSTG-1:0] vld_reg;
    stage_t          stg_reg  [NSTG];
    stage_t          stg_next [NSTG];
    logic            keep_last;
    logic            adv;

    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < NUM_COEFF; k++)
                coeff_reg[k] <= ZERO_Q16;
            offset_reg    <= ZERO_Q16;
            inv_scale_reg <= ONE_Q16;
        end
        else if (cfg.valid)
        begin
            unique case (cfg.index) inside
                [REG_COEFF_FIRST:REG_COEFF_LAST]: coeff_reg[cfg.index] <= cfg.data;
                REG_OFFSET:                       offset_reg <= cfg.data;
                REG_INV_SCALE:                    inv_scale_reg <= cfg.data;
                default:
                begin
                end
            endcase
        end
    end

    for (genvar k = 0; k < NUM_POW; k++)
    begin : g_coef
        if (k < NUM_COEFF)
        begin : g_reg
            assign coef_ext[k] = coeff_reg[k];
        end
        else
        begin : g_zero
            assign coef_ext[k] = ZERO_Q16;
        end
    end

    // basis beats with an empty mask leave nothing behind
    assign keep_last  = (stg_reg[LAST_ST].kind == KIND_EVAL) || (|stg_reg[LAST_ST].mask);
    assign adv        = !(vld_reg[LAST_ST] && keep_last && q_full);
    assign sample.ready = adv;
    assign push_valid = vld_reg[LAST_ST] && keep_last && !q_full;

    always_comb
    begin
        push_data      = '0;
        push_data.kind = stg_reg[LAST_ST].kind;
        push_data.mask = stg_reg[LAST_ST].mask;
        push_data.acc  = stg_reg[LAST_ST].acc;
        push_data.pw   = stg_reg[LAST_ST].pw;
    end

    always_comb
    begin
        stg_next[0]       = '0;
        stg_next[0].kind  = sample.kind;
        stg_next[0].mask  = sample.power_mask[USE_W-1:0];
        stg_next[0].u     = sat_sub(sample.x, offset_reg);
        stg_next[0].pw[0] = ONE_Q16;
    end

    for (genvar s = 1; s < NSTG; s++)
    begin : g_stg
        if (s == 1)
        begin : g_norm
            always_comb
            begin
                stg_next[s]       = stg_reg[s-1];
                stg_next[s].u     = mul_q16(stg_reg[s-1].u, inv_scale_reg);
                stg_next[s].pw[1] = stg_next[s].u;
            end
        end
        else if (s <= MAX_ORDER)
        begin : g_pow
            always_comb
            begin
                stg_next[s]       = stg_reg[s-1];
                stg_next[s].pw[s] = mul_q16(stg_reg[s-1].pw[s-1], stg_reg[s-1].u);
            end
        end
        else if (s == ST_TERM)
        begin : g_term
            always_comb
            begin
                stg_next[s] = stg_reg[s-1];
                for (int k = 0; k < NUM_POW; k++)
                    stg_next[s].term[k] = mul_q16(coef_ext[k], stg_reg[s-1].pw[k]);
            end
        end
        else
        begin : g_acc
            always_comb
            begin
                stg_next[s]     = stg_reg[s-1];
                stg_next[s].acc = sat_add(stg_reg[s-1].acc, stg_reg[s-1].term[s-ST_ACC0]);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else if (adv)
            vld_reg <= {vld_reg[NSTG-2:0], sample.valid};
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int s = 0; s < NSTG; s++)
                stg_reg[s] <= stg_next[s];
        end
    end

endmodule

`default_nettype wire

/* rtl/core/npe_queue.sv */
// short queue between front and back ends
`default_nettype none

module npe_queue (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            push,
    input  wire npe_pkg::entry_t push_data,
    input  wire logic            pop,
    output logic                 full,
    output logic                 head_valid,
    output npe_pkg::entry_t      head
);
    import npe_pkg::*;

    entry_t               mem_reg [Q_DEPTH];
    logic [Q_PTR_W-1:0]   wr_ptr_reg;
    logic [Q_PTR_W-1:0]   rd_ptr_reg;
    logic [Q_CNT_W-1:0]   cnt_reg;

    assign full       = (cnt_reg == Q_CNT_W'(Q_DEPTH));
    assign head_valid = (cnt_reg != '0);
    assign head       = mem_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wr_ptr_reg] <= push_data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            if (pop)
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            if (push && !pop)
                cnt_reg <= cnt_reg + 1'b1;
            else if (pop && !push)
                cnt_reg <= cnt_reg - 1'b1;
        end
    end

endmodule

`default_nettype wire

/* rtl/core/npe_back.sv */
// back end: walks the power mask and drives the result register
`default_nettype none

module npe_back (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            head_valid,
    input  wire npe_pkg::entry_t head,
    output logic                 pop,
    npe_out_if.source            result
);
    import npe_pkg::*;

    logic              out_vld_reg;
    q16_t              val_reg;
    logic [PIDX_W-1:0] idx_reg;
    logic              last_reg;
    logic              mid_reg;
    logic [USE_W-1:0]  rem_reg;

    logic [USE_W-1:0]  eff_mask;
    logic [USE_W-1:0]  low_bit;
    logic [USE_W-1:0]  rest;
    logic [IDX_W-1:0]  low_idx;
    logic              is_eval;
    logic              is_last;
    logic              load;

    assign eff_mask = mid_reg ? rem_reg : head.mask;
    assign low_bit  = eff_mask & (~eff_mask + 1'b1);
    assign rest     = eff_mask & ~low_bit;
    assign is_eval  = (head.kind == KIND_EVAL);
    assign is_last  = is_eval || (rest == '0);
    assign load     = head_valid && (!out_vld_reg || result.ready);
    assign pop      = load && is_last;

    always_comb
    begin
        low_idx = '0;
        for (int k = USE_W - 1; k >= 0; k--)
        begin
            if (eff_mask[k])
                low_idx = IDX_W'(k);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_vld_reg <= 1'b0;
            mid_reg     <= 1'b0;
            rem_reg     <= '0;
        end
        else
        begin
            if (load)
                out_vld_reg <= 1'b1;
            else if (result.ready)
                out_vld_reg <= 1'b0;
            if (load)
            begin
                mid_reg <= !is_last;
                rem_reg <= rest;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            val_reg  <= is_eval ? head.acc : head.pw[low_idx];
            idx_reg  <= is_eval ? '0 : PIDX_W'(low_idx);
            last_reg <= is_last;
        end
    end

    assign result.valid        = out_vld_reg;
    assign result.result_value = val_reg;
    assign result.power_index  = idx_reg;
    assign result.last         = last_reg;

endmodule

`default_nettype wire

/* rtl/core/normalized_poly_eval.sv */
// top level of the normalized polynomial evaluator
//
// sample channel: kind, x (q16.16) and power_mask; a beat is taken when valid and ready
// are high. x is normalized to u = (x - offset) * inv_scale and the powers u^0..u^5 are
// formed in a pipeline of 13 stages, one multiplier per stage in the power chain.
// kind 0 gives one beat on the result channel: the saturated sum of coeff_k * u^k, with
// power_index 0 and last set. kind 1 gives one beat per set mask bit, ascending, last on
// the highest; an empty mask gives none.
// cfg channel: index 0..5 coefficients, 6 offset, 7 inv_scale; always ready, write only
// while no sample is in flight.
// a sample passes the stage registers, the queue and the result register; evaluate beats
// sustain one per cycle while the receiver is ready; basis beats give one per requested power.
// a four-entry queue parts the pipeline from the result side; a stalled receiver stops
// sample intake once the queue is full and a beat with results waits at the last stage.
// reset clears all valid state and loads coefficients and offset 0, inv_scale 1.0.
`default_nettype none

module normalized_poly_eval (
    input  wire logic clk,
    input  wire logic rst_n,
    npe_in_if.sink    sample,
    npe_cfg_if.sink   cfg,
    npe_out_if.source result
);
    import npe_pkg::*;

    logic   q_push;
    entry_t q_push_data;
    logic   q_pop;
    logic   q_full;
    logic   q_valid;
    entry_t q_head;

    npe_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .sample     (sample),
        .cfg        (cfg),
        .q_full     (q_full),
        .push_valid (q_push),
        .push_data  (q_push_data)
    );

    npe_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (q_push),
        .push_data  (q_push_data),
        .pop        (q_pop),
        .full       (q_full),
        .head_valid (q_valid),
        .head       (q_head)
    );

    npe_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head_valid (q_valid),
        .head       (q_head),
        .pop        (q_pop),
        .result     (result)
    );

`ifndef SYNTH
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        !(q_push && q_full && !q_pop))
        else $error("queue written while full");

    a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |-> q_valid)
        else $error("queue popped while empty");

    a_index_rises: assert property (@(posedge clk) disable iff (!rst_n)
        (result.valid && result.ready && !result.last)
        |=> (!result.valid || (result.power_index > $past(result.power_index))))
        else $error("basis powers out of order");
`endif

endmodule

`default_nettype wire

/* verif/normalized_poly_eval_tb.sv */
// self-checking testbench for normalized_poly_eval: evaluate and basis beats against a shadow predictor
`default_nettype none

module normalized_poly_eval_tb;
    import npe_pkg::*;

    localparam int CYCLE_LIMIT    = 200000;
    localparam int SETTLE_CYCLES  = 20;
    localparam int RAND_PHASES    = 6;
    localparam int RAND_PER_PHASE = 49;
    localparam int REPORT_CAP     = 40;

    typedef struct {
        logic              kind;
        q16_t              x;
        logic [MASK_W-1:0] mask;
    } sample_item_t;

    typedef struct {
        q16_t              value;
        logic [PIDX_W-1:0] pidx;
        logic              last;
    } result_beat_t;

    logic clk = 1'b0;
    logic rst_n;

    npe_in_if  sample_ch ();
    npe_cfg_if cfg_ch ();
    npe_out_if result_ch ();

    normalized_poly_eval i_dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .sample (sample_ch),
        .cfg    (cfg_ch),
        .result (result_ch)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // shadow copy of the register file
    q16_t coeff_q [NUM_COEFF];
    q16_t norm_offset;
    q16_t norm_inv_scale;

    sample_item_t sample_queue [$];
    result_beat_t expected_beats [$];
    sample_item_t next_sample;
    result_beat_t got_beat;
    result_beat_t want_beat;

    int  send_idle_pct;
    int  recv_stall_pct;
    logic in_beat;
    int  cycle_count;
    int  err_count;
    int  samples_taken;
    int  eval_samples;
    int  basis_samples;
    int  beats_checked;
    int  reg_writes;
    int  settings_used;

    task automatic report_mismatch(input string msg);
        err_count++;
        if (err_count <= REPORT_CAP)
            $display("mismatch at cycle %0d: %s", cycle_count, msg);
    endtask

    function automatic q16_t clamp_q16(input longint v);
        if (v > longint'(Q16_MAX))
            return Q16_MAX;
        if (v < longint'(Q16_MIN))
            return Q16_MIN;
        return q16_t'(v);
    endfunction

    // q16.16 product, round half up
    function automatic q16_t fix_mul(input q16_t a, input q16_t b);
        longint prod;
        prod = longint'(a) * longint'(b) + 64'sd32768;
        return clamp_q16(prod >>> 16);
    endfunction

    task automatic predict_beats(input logic kind, input q16_t x, input logic [MASK_W-1:0] mask);
        q16_t         u;
        q16_t         pw [MAX_ORDER+1];
        q16_t         acc;
        q16_t         c;
        int           top;
        result_beat_t beat;
        u = fix_mul(clamp_q16(longint'(x) - longint'(norm_offset)), norm_inv_scale);
        pw[0] = ONE_Q16;
        for (int k = 1; k <= MAX_ORDER; k++)
            pw[k] = fix_mul(pw[k-1], u);
        if (kind == KIND_EVAL)
        begin
            acc = ZERO_Q16;
            for (int k = 0; k <= MAX_ORDER; k++)
            begin
                c = (k < NUM_COEFF) ? coeff_q[k] : ZERO_Q16;
                acc = clamp_q16(longint'(acc) + longint'(fix_mul(c, pw[k])));
            end
            beat.value = acc;
            beat.pidx  = '0;
            beat.last  = 1'b1;
            expected_beats.push_back(beat);
            eval_samples++;
        end
        else
        begin
            top = -1;
            for (int k = 0; k <= MAX_ORDER && k < MASK_W; k++)
                if (mask[k])
                    top = k;
            for (int k = 0; k <= top; k++)
                if (mask[k])
                begin
                    beat.value = pw[k];
                    beat.pidx  = PIDX_W'(k);
                    beat.last  = (k == top);
                    expected_beats.push_back(beat);
                end
            basis_samples++;
        end
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input q16_t val);
        @(negedge clk);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= val;
        do
            @(posedge clk);
        while (!cfg_ch.ready);
        if (idx <= REG_COEFF_LAST)
            coeff_q[idx - REG_COEFF_FIRST] = val;
        else if (idx == REG_OFFSET)
            norm_offset = val;
        else if (idx == REG_INV_SCALE)
            norm_inv_scale = val;
        reg_writes++;
        @(negedge clk);
        cfg_ch.valid <= 1'b0;
    endtask

    function automatic q16_t pick_small(input int span);
        return q16_t'(int'($urandom_range(0, 2 * span)) - span);
    endfunction

    function automatic q16_t pick_wide();
        case ($urandom_range(0, 5))
            0: return Q16_MAX;
            1: return Q16_MIN;
            2, 3: return q16_t'($urandom);
            default: return pick_small(131072);
        endcase
    endfunction

    function automatic q16_t pick_inv_scale();
        case ($urandom_range(0, 9))
            0: return ZERO_Q16;
            1: return pick_wide();
            default: return pick_small(131072);
        endcase
    endfunction

    function automatic sample_item_t random_sample();
        sample_item_t s;
        s.kind = ($urandom_range(0, 99) < 45) ? KIND_EVAL : KIND_BASIS;
        s.x    = ($urandom_range(0, 9) < 7) ? pick_small(262144) : q16_t'($urandom);
        s.mask = ($urandom_range(0, 9) == 0) ? '0 : MASK_W'($urandom_range(0, 63));
        return s;
    endfunction

    function automatic sample_item_t mk(input logic kind, input q16_t x,
                                        input logic [MASK_W-1:0] mask);
        sample_item_t s;
        s.kind = kind;
        s.x    = x;
        s.mask = mask;
        return s;
    endfunction

    // style 0 random, 1 top extremes, 2 bottom extremes, 3 hand-picked mix
    task automatic load_settings(input int style);
        q16_t mix [NUM_COEFF];
        mix = '{32'sh0001_0000, 32'sh0002_0000, -32'sh0000_8000,
                32'sh0000_4000, Q16_MAX, Q16_MIN};
        for (int k = 0; k < NUM_COEFF; k++)
            case (style)
                1: write_reg(REG_COEFF_FIRST + CFG_IDX_W'(k), Q16_MAX);
                2: write_reg(REG_COEFF_FIRST + CFG_IDX_W'(k), Q16_MIN);
                3: write_reg(REG_COEFF_FIRST + CFG_IDX_W'(k), mix[k]);
                default: write_reg(REG_COEFF_FIRST + CFG_IDX_W'(k), pick_wide());
            endcase
        case (style)
            1:
            begin
                write_reg(REG_OFFSET, Q16_MIN);
                write_reg(REG_INV_SCALE, Q16_MAX);
            end
            2:
            begin
                write_reg(REG_OFFSET, Q16_MAX);
                write_reg(REG_INV_SCALE, Q16_MIN);
            end
            3:
            begin
                write_reg(REG_OFFSET, ONE_Q16);
                write_reg(REG_INV_SCALE, 32'sh0000_8000);
            end
            default:
            begin
                write_reg(REG_OFFSET,
                          ($urandom_range(0, 4) == 0) ? pick_wide() : pick_small(131072));
                write_reg(REG_INV_SCALE, pick_inv_scale());
            end
        endcase
        settings_used++;
    endtask

    task automatic drain_and_settle();
        while (sample_queue.size() != 0 || sample_ch.valid)
            @(posedge clk);
        while (expected_beats.size() != 0)
            @(posedge clk);
        // empty-mask samples leave no beat behind, so give the pipeline time to empty
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // sample driver
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (!sample_ch.valid || in_beat)
            begin
                if (sample_queue.size() != 0 && $urandom_range(0, 99) >= send_idle_pct)
                begin
                    next_sample = sample_queue.pop_front();
                    sample_ch.valid      <= 1'b1;
                    sample_ch.kind       <= next_sample.kind;
                    sample_ch.x          <= next_sample.x;
                    sample_ch.power_mask <= next_sample.mask;
                end
                else
                    sample_ch.valid <= 1'b0;
            end
            result_ch.ready <= ($urandom_range(0, 99) >= recv_stall_pct);
        end
    end

    // monitor and scoreboard
    always @(posedge clk)
    begin
        in_beat = rst_n && sample_ch.valid && sample_ch.ready;
        if (rst_n)
            cycle_count++;
        if (in_beat)
        begin
            predict_beats(sample_ch.kind, sample_ch.x, sample_ch.power_mask);
            samples_taken++;
        end
        if (rst_n && result_ch.valid && result_ch.ready)
        begin
            got_beat.value = result_ch.result_value;
            got_beat.pidx  = result_ch.power_index;
            got_beat.last  = result_ch.last;
            if (expected_beats.size() == 0)
                report_mismatch($sformatf("result beat with nothing expected: value %h idx %0d last %0b",
                                          got_beat.value, got_beat.pidx, got_beat.last));
            else
            begin
                want_beat = expected_beats.pop_front();
                if (got_beat.value !== want_beat.value)
                    report_mismatch($sformatf("result_value %h, expected %h (power %0d)",
                                              got_beat.value, want_beat.value, want_beat.pidx));
                if (got_beat.pidx !== want_beat.pidx)
                    report_mismatch($sformatf("power_index %0d, expected %0d",
                                              got_beat.pidx, want_beat.pidx));
                if (got_beat.last !== want_beat.last)
                    report_mismatch($sformatf("last %0b, expected %0b (power %0d)",
                                              got_beat.last, want_beat.last, want_beat.pidx));
                beats_checked++;
            end
        end
    end

    // watchdog
    initial
    begin
        while (cycle_count < CYCLE_LIMIT)
            @(posedge clk);
        $display("timeout after %0d cycles, %0d beats still expected",
                 cycle_count, expected_beats.size());
        $display("== FAIL ==");
        $finish;
    end

    initial
    begin
        rst_n                = 1'b0;
        sample_ch.valid      = 1'b0;
        sample_ch.kind       = KIND_EVAL;
        sample_ch.x          = ZERO_Q16;
        sample_ch.power_mask = '0;
        cfg_ch.valid         = 1'b0;
        cfg_ch.index         = REG_COEFF_FIRST;
        cfg_ch.data          = ZERO_Q16;
        result_ch.ready      = 1'b0;
        in_beat              = 1'b0;
        cycle_count          = 0;
        err_count            = 0;
        samples_taken        = 0;
        eval_samples         = 0;
        basis_samples        = 0;
        beats_checked        = 0;
        reg_writes           = 0;
        settings_used        = 1;
        for (int k = 0; k < NUM_COEFF; k++)
            coeff_q[k] = ZERO_Q16;
        norm_offset    = ZERO_Q16;
        norm_inv_scale = ONE_Q16;
        send_idle_pct  = 15;
        recv_stall_pct = 85;

        repeat (3) @(negedge clk);
        rst_n <= 1'b1;

        // reset settings: all-zero polynomial, identity normalisation
        sample_queue.push_back(mk(KIND_EVAL,  ZERO_Q16, '0));
        sample_queue.push_back(mk(KIND_EVAL,  Q16_MAX, 6'h3f));
        sample_queue.push_back(mk(KIND_BASIS, 32'sh0002_0000, 6'h3f));
        sample_queue.push_back(mk(KIND_BASIS, -32'sh0001_8000, 6'h00));
        sample_queue.push_back(mk(KIND_BASIS, Q16_MIN, 6'h01));
        sample_queue.push_back(mk(KIND_BASIS, Q16_MAX, 6'h20));
        drain_and_settle();

        load_settings(3);
        sample_queue.push_back(mk(KIND_EVAL,  ZERO_Q16, 6'h00));
        sample_queue.push_back(mk(KIND_EVAL,  ONE_Q16, 6'h15));
        sample_queue.push_back(mk(KIND_EVAL,  -32'sh0003_0000, 6'h00));
        sample_queue.push_back(mk(KIND_EVAL,  Q16_MAX, 6'h00));
        sample_queue.push_back(mk(KIND_EVAL,  Q16_MIN, 6'h3f));
        sample_queue.push_back(mk(KIND_EVAL,  32'sh0003_0000, 6'h00));
        sample_queue.push_back(mk(KIND_BASIS, 32'sh0002_8000, 6'h15));
        sample_queue.push_back(mk(KIND_BASIS, 32'sh0002_8000, 6'h2a));
        sample_queue.push_back(mk(KIND_BASIS, -32'sh0004_0000, 6'h3f));
        sample_queue.push_back(mk(KIND_BASIS, Q16_MIN, 6'h3f));
        sample_queue.push_back(mk(KIND_BASIS, Q16_MAX, 6'h21));
        sample_queue.push_back(mk(KIND_BASIS, ONE_Q16, 6'h00));
        sample_queue.push_back(mk(KIND_BASIS, -32'sh0000_c000, 6'h01));
        drain_and_settle();

        for (int phase = 0; phase < RAND_PHASES; phase++)
        begin
            send_idle_pct  = (phase < 2) ? 15 : (phase < 4) ? 85 : 0;
            recv_stall_pct = (phase < 2) ? 85 : (phase < 4) ? 15 : 0;
            load_settings((phase == 2) ? 1 : (phase == 3) ? 2 : 0);
            repeat (RAND_PER_PHASE) sample_queue.push_back(random_sample());
            drain_and_settle();
        end

        $display("covered %0d samples (%0d evaluate, %0d basis), %0d result beats checked",
                 samples_taken, eval_samples, basis_samples, beats_checked);
        $display("across %0d register settings (%0d writes) and three flow-control mixes",
                 settings_used, reg_writes);
        if (err_count == 0 && expected_beats.size() == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule

`default_nettype wire
